// File: rtl/core/json_string_field_extractor_core_macros.svh
// Assertion helpers shared by the core files.
`ifndef JSON_STRING_FIELD_EXTRACTOR_CORE_MACROS_SVH
`define JSON_STRING_FIELD_EXTRACTOR_CORE_MACROS_SVH

// Checked only outside reset.
`define JSFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define JSFE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: rtl/core/jsfe_pkg.sv
package jsfe_pkg;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_PRE_COLON,
    PH_POST_COLON,
    PH_VALUE,
    PH_ESCAPE,
    PH_IDLE
  } phase_t;

  typedef enum logic [2:0] {
    CFG_KEY_LOW,
    CFG_KEY_MID_LOW,
    CFG_KEY_MID_HIGH,
    CFG_KEY_HIGH,
    CFG_KEY_LENGTH,
    CFG_MAX_VALUE
  } cfg_index_t;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned KEY_LEN_W  = 6;
  localparam int unsigned COUNT_W    = 16;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       doc_done;
    logic       lookup_status;
  } result_t;

endpackage

// File: rtl/core/jsfe_match_cell.sv
module jsfe_match_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic       clear,
  input  logic       prev_hit,
  input  logic [7:0] text_byte,
  input  logic [7:0] pat_char,
  output logic       hit,
  output logic       hit_next
);
  // The stream ends in this cell's pattern prefix when the neighbor's
  // shorter prefix held one byte ago and this byte is the next character.
  assign hit_next = prev_hit && (text_byte == pat_char);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hit <= 1'b0;
    end else if (shift) begin
      hit <= hit_next;
    end
  end

endmodule

// File: rtl/core/jsfe_out_queue.sv
`include "json_string_field_extractor_core_macros.svh"

module jsfe_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jsfe_pkg::result_t push_data,
  output logic              can_push,
  output logic              head_valid,
  input  logic              head_ready,
  output jsfe_pkg::result_t head_data
);
  import jsfe_pkg::*;

  logic    head_full;
  logic    skid_full;
  result_t head_q;
  result_t skid_q;
  logic    pop;

  assign pop        = head_full && head_ready;
  assign can_push   = !skid_full;
  assign head_valid = head_full;
  assign head_data  = head_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_full <= 1'b0;
      skid_full <= 1'b0;
    end else if (!head_full || pop) begin
      if (skid_full) begin
        head_full <= 1'b1;
        skid_full <= push;
      end else begin
        head_full <= push;
      end
    end else if (push) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_full || pop) begin
      if (skid_full) begin
        head_q <= skid_q;
        if (push) begin
          skid_q <= push_data;
        end
      end else if (push) begin
        head_q <= push_data;
      end
    end else if (push) begin
      skid_q <= push_data;
    end
  end

  `JSFE_ASSERT(a_skid_behind_head, skid_full |-> head_full, "skid holds data with empty head")
  `JSFE_ASSERT(a_full_stalls_push, (!can_push) |-> head_valid, "input stalled with no result")
  `JSFE_ASSERT_ALWAYS(a_empty_after_rst, rst |=> !head_valid, "result shown after reset")

endmodule

// File: rtl/core/json_string_field_extractor_core.sv
// A value byte or end-of-document status is registered in the output queue, in its head
// register or, when the head is full, in its skid register, before it reaches the result port.
// Throughput: one text byte per cycle; the match window is a row of cells that
// all compare in parallel. Input stalls only when both output stages are full.
// Reset (synchronous): parser back to key search, window and count cleared,
// key registers zero, key length zero, value limit 255. No clearing pass.
`include "json_string_field_extractor_core_macros.svh"

module json_string_field_extractor_core #(
  parameter int unsigned MAX_KEY_BYTES = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [jsfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jsfe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           text_valid,
  output logic                           text_ready,
  input  logic [7:0]                     text_byte,
  input  logic                           text_last,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_valid,
  output logic                           doc_done,
  output logic                           lookup_status
);
  import jsfe_pkg::*;

  localparam int unsigned WIN   = MAX_KEY_BYTES + 2;
  localparam int unsigned SEL_W = $clog2(WIN + 1);

  logic [CFG_DATA_W-1:0] key_low;
  logic [CFG_DATA_W-1:0] key_mid_low;
  logic [CFG_DATA_W-1:0] key_mid_high;
  logic [CFG_DATA_W-1:0] key_high;
  logic [KEY_LEN_W-1:0]  key_length;
  logic [COUNT_W-1:0]    max_value_bytes;

  logic [4*CFG_DATA_W-1:0]    key_full;
  logic [8*MAX_KEY_BYTES-1:0] key_all;
  logic [KEY_LEN_W-1:0]       len_eff;
  logic [SEL_W-1:0]           hit_sel;

  phase_t             phase;
  phase_t             phase_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] count_next;

  logic       accept;
  logic       emit;
  logic [7:0] emit_byte;
  logic       window_hit;
  logic       shift;
  logic       doc_clear;
  logic       is_blank;
  logic       at_limit;

  logic [WIN:0] hit_q;
  logic [WIN:0] hit_d;

  result_t res;
  result_t head;
  logic    push;
  logic    can_push;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low         <= '0;
      key_mid_low     <= '0;
      key_mid_high    <= '0;
      key_high        <= '0;
      key_length      <= '0;
      max_value_bytes <= COUNT_W'(255);
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_KEY_LOW:      key_low         <= cfg_data;
        CFG_KEY_MID_LOW:  key_mid_low     <= cfg_data;
        CFG_KEY_MID_HIGH: key_mid_high    <= cfg_data;
        CFG_KEY_HIGH:     key_high        <= cfg_data;
        CFG_KEY_LENGTH:   key_length      <= cfg_data[KEY_LEN_W-1:0];
        CFG_MAX_VALUE:    max_value_bytes <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign key_full = {key_high, key_mid_high, key_mid_low, key_low};
  assign key_all  = key_full[8*MAX_KEY_BYTES-1:0];
  assign len_eff  = (key_length > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                    KEY_LEN_W'(MAX_KEY_BYTES) : key_length;
  assign hit_sel  = SEL_W'(len_eff) + SEL_W'(2);

  assign accept    = text_valid && text_ready;
  assign shift     = accept && (phase == PH_SEARCH) && (text_byte != 8'h00);
  assign doc_clear = accept && text_last;

  // Match chain: cell k tracks "last k bytes equal the first k pattern bytes",
  // pattern being quote, key characters, quote.
  assign hit_q[0] = 1'b1;
  assign hit_d[0] = 1'b1;

  for (genvar k = 1; k <= WIN; k++) begin : g_cell
    logic [7:0] pat;
    if (k == 1) begin : g_open
      assign pat = CH_QUOTE;
    end else if (k - 2 < MAX_KEY_BYTES) begin : g_key
      assign pat = (len_eff == KEY_LEN_W'(k - 2)) ? CH_QUOTE : key_all[8*(k-2) +: 8];
    end else begin : g_close
      assign pat = CH_QUOTE;
    end

    jsfe_match_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .clear     (doc_clear),
      .prev_hit  (hit_q[k-1]),
      .text_byte (text_byte),
      .pat_char  (pat),
      .hit       (hit_q[k]),
      .hit_next  (hit_d[k])
    );
  end

  assign window_hit = hit_d[hit_sel];

  assign is_blank  = (text_byte == CH_SPACE) || (text_byte == CH_TAB);
  assign at_limit  = (count >= max_value_bytes);
  assign count_inc = count + COUNT_W'(emit);

  // Next state
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if ((phase != PH_IDLE) && (text_byte == 8'h00)) begin
        phase_next = PH_IDLE;
      end else begin
        case (phase)
          PH_SEARCH: begin
            if (window_hit) phase_next = PH_PRE_COLON;
          end
          PH_PRE_COLON: begin
            if (text_byte == CH_COLON) phase_next = PH_POST_COLON;
            else if (!is_blank) phase_next = PH_IDLE;
          end
          PH_POST_COLON: begin
            if (text_byte == CH_QUOTE) begin
              phase_next = (max_value_bytes == '0) ? PH_IDLE : PH_VALUE;
            end else if (!is_blank) begin
              phase_next = PH_IDLE;
            end
          end
          PH_VALUE: begin
            if (at_limit || (text_byte == CH_QUOTE)) phase_next = PH_IDLE;
            else if ((text_byte == CH_BSLASH) && !text_last) phase_next = PH_ESCAPE;
          end
          PH_ESCAPE: phase_next = PH_VALUE;
          default: ;
        endcase
      end
      if ((phase_next == PH_VALUE) && (count_inc >= max_value_bytes)) begin
        phase_next = PH_IDLE;
      end
      if (text_last) begin
        phase_next = PH_SEARCH;
      end
    end
  end

  // Outputs of the parser
  always_comb begin
    emit      = 1'b0;
    emit_byte = 8'h00;
    if (accept) begin
      if ((phase != PH_IDLE) && (text_byte == 8'h00)) begin
        // backslash right before the terminator stands for itself
        if (phase == PH_ESCAPE) begin
          emit      = 1'b1;
          emit_byte = CH_BSLASH;
        end
      end else begin
        case (phase)
          PH_VALUE: begin
            if (!at_limit && (text_byte != CH_QUOTE) &&
                !((text_byte == CH_BSLASH) && !text_last)) begin
              emit      = 1'b1;
              emit_byte = text_byte;
            end
          end
          PH_ESCAPE: begin
            emit      = 1'b1;
            emit_byte = text_byte;
          end
          default: ;
        endcase
      end
    end
  end

  assign count_next = doc_clear ? '0 : (accept ? count_inc : count);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  assign res.out_byte      = emit_byte;
  assign res.out_valid     = emit;
  assign res.doc_done      = text_last;
  assign res.lookup_status = text_last && (count_inc == '0);
  assign push              = accept && (emit || text_last);

  jsfe_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (res),
    .can_push   (can_push),
    .head_valid (result_valid),
    .head_ready (result_ready),
    .head_data  (head)
  );

  assign text_ready    = can_push;
  assign out_byte      = head.out_byte;
  assign out_valid     = head.out_valid;
  assign doc_done      = head.doc_done;
  assign lookup_status = head.lookup_status;

  `JSFE_ASSERT(a_emit_in_value, emit |-> (phase == PH_VALUE || phase == PH_ESCAPE), "byte emitted outside value")
  `JSFE_ASSERT(a_restart_after_last, doc_clear |=> (phase == PH_SEARCH && count == '0), "no restart after last byte")
  `JSFE_ASSERT(a_ready_without_result, (!result_valid) |-> text_ready, "input stalled with empty output")

endmodule
